### sv/ppm_pkg.sv
// ----------------------------------------------------------------------------
// Pseudocolor mapper package
// Shared widths and the fixed signed Q11.24 polynomial coefficient tables.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int ACC_W  = 36;
  localparam int T_W    = 17;
  localparam int QBITS  = 16;
  localparam int FRAC_W = 24;
  localparam int TAB_LEN = 16;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef enum logic {
    REG_COLOR_MAX = 1'b0,
    REG_MAP_MODE  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       mode;
    logic       blue_only;
    logic [7:0] lin;
  } side_t;

  localparam acc_t RED_POLY [TAB_LEN] = '{
    36'sd4395558, 36'sd12794207, -36'sd133471131, 36'sd476860860, -36'sd840288765,
    36'sd324629028, 36'sd722883581, -36'sd190587387, -36'sd855202527, 36'sd494803454,
    36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd0
  };

  localparam acc_t GREEN_POLY [TAB_LEN] = '{
    36'sd70255, 36'sd24893622, -36'sd14972315, -36'sd3015668, 36'sd16841299,
    36'sd9976204, -36'sd8195012, -36'sd18044434, -36'sd10014487, 36'sd17676375,
    36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd0
  };

  localparam acc_t BLUE_POLY [TAB_LEN] = '{
    36'sd5408854, 36'sd32586751, -36'sd113110271, 36'sd227699023, -36'sd250990027,
    36'sd17757340, 36'sd232296410, -36'sd39197153, -36'sd335435311, 36'sd225365467,
    36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd0, 36'sd0
  };

  function automatic acc_t coef(input chan_t ch, input logic [3:0] idx);
    acc_t c;
    case (ch)
      CH_RED:   c = RED_POLY[idx];
      CH_GREEN: c = GREEN_POLY[idx];
      CH_BLUE:  c = BLUE_POLY[idx];
      default:  c = '0;
    endcase
    return c;
  endfunction

endpackage

### sv/polynomial_pseudocolor_mapper_top.sv
// ----------------------------------------------------------------------------
// Polynomial pseudocolor mapper
// Maps one unsigned pixel count to an 8-bit RGB word, viridis or blue-white.
// ----------------------------------------------------------------------------
// A new pixel word is taken in every clock cycle; busy never rises. Each word
// passes through the input register, loaded at the edge that takes it, one
// dividend setup stage, 16 stages of the one-bit-per-stage divider that forms
// the normalized count, one clamp stage, a multiply stage and an add stage for
// each of the COEFF_COUNT-1 Horner steps, and the output register. The result
// is shown with out_valid for exactly one cycle and cannot be held back by the
// receiver.
module polynomial_pseudocolor_mapper_top #(
  parameter int COEFF_COUNT = 10,
  parameter int VALUE_BITS  = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_pixel_value,
  output logic                  out_valid,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int VB    = VALUE_BITS;
  localparam int DV_W  = VB + 1;
  localparam int RW    = VB + 2;
  localparam int NQ    = ppm_pkg::QBITS;
  localparam int STEPS = COEFF_COUNT - 1;
  localparam int AW    = ppm_pkg::ACC_W;
  localparam int PW    = AW + ppm_pkg::T_W + 1;
  localparam int FW    = AW + 9;

  logic [VB-1:0] color_max_r;
  logic          map_mode_r;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_max_r <= '1;
      map_mode_r  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ppm_pkg::REG_COLOR_MAX) begin
        color_max_r <= pwdata[VB-1:0];
      end else begin
        map_mode_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ppm_pkg::REG_COLOR_MAX) begin
      prdata[VB-1:0] = color_max_r;
    end else begin
      prdata[0] = map_mode_r;
    end
  end

  // Input register.
  logic          v0_r;
  logic [VB-1:0] pix0_r;
  logic [VB-1:0] cmax0_r;
  logic          mode0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    pix0_r  <= in_pixel_value;
    cmax0_r <= (color_max_r == '0) ? VB'(1) : color_max_r;
    mode0_r <= map_mode_r;
  end

  // Dividend setup: the viridis map divides v*2^16 by cmax, the linear map
  // divides 510*(cmax-v)+cmax by 2*cmax.
  logic [VB+8:0] lin_num;
  logic [VB+8:0] diff_ext;
  assign diff_ext = (VB+9)'(cmax0_r - pix0_r);
  assign lin_num  = (diff_ext << 9) - diff_ext - diff_ext + (VB+9)'(cmax0_r);

  logic          dv_r   [NQ+1];
  logic [RW-1:0] rem_r  [NQ+1];
  logic [NQ-1:0] low_r  [NQ+1];
  logic [NQ-1:0] quo_r  [NQ+1];
  logic [DV_W-1:0] dvs_r [NQ+1];
  logic          dmode_r [NQ+1];
  logic          over_r  [NQ+1];
  logic          bover_r [NQ+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else begin
      dv_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    dmode_r[0] <= mode0_r;
    over_r[0]  <= (pix0_r >= cmax0_r);
    bover_r[0] <= (pix0_r > cmax0_r);
    quo_r[0]   <= '0;
    if (mode0_r) begin
      rem_r[0] <= RW'(lin_num >> NQ);
      low_r[0] <= lin_num[NQ-1:0];
      dvs_r[0] <= {cmax0_r, 1'b0};
    end else begin
      rem_r[0] <= RW'(pix0_r);
      low_r[0] <= '0;
      dvs_r[0] <= DV_W'(cmax0_r);
    end
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div
    logic [RW-1:0] rem2;
    logic          ge;
    assign rem2 = {rem_r[j][RW-2:0], low_r[j][NQ-1]};
    assign ge   = (rem2 >= RW'(dvs_r[j]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j+1]   <= ge ? (rem2 - RW'(dvs_r[j])) : rem2;
      quo_r[j+1]   <= {quo_r[j][NQ-2:0], ge};
      low_r[j+1]   <= {low_r[j][NQ-2:0], 1'b0};
      dvs_r[j+1]   <= dvs_r[j];
      dmode_r[j+1] <= dmode_r[j];
      over_r[j+1]  <= over_r[j];
      bover_r[j+1] <= bover_r[j];
    end
  end

  // Clamp stage: t in unsigned Q1.16 and the linear level.
  logic                        tv_r;
  logic [ppm_pkg::T_W-1:0]     tt_r;
  ppm_pkg::side_t              ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else begin
      tv_r <= dv_r[NQ];
    end
  end

  always_ff @(posedge clk) begin
    tt_r           <= over_r[NQ] ? (ppm_pkg::T_W)'(1 << NQ) : {1'b0, quo_r[NQ]};
    ts_r.mode      <= dmode_r[NQ];
    ts_r.blue_only <= bover_r[NQ];
    ts_r.lin       <= quo_r[NQ][7:0];
  end

  // Horner steps: multiply stage then shift-and-add stage, three channels.
  logic                    mv_r [STEPS];
  logic                    av_r [STEPS];
  logic [ppm_pkg::T_W-1:0] mt_r [STEPS];
  logic [ppm_pkg::T_W-1:0] at_r [STEPS];
  ppm_pkg::side_t          ms_r [STEPS];
  ppm_pkg::side_t          as_r [STEPS];
  logic signed [PW-1:0]    prod_r [STEPS][3];
  ppm_pkg::acc_t           acc_r  [STEPS][3];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                    in_v;
    logic [ppm_pkg::T_W-1:0] in_t;
    ppm_pkg::side_t          in_s;

    if (k == 0) begin : g_first
      assign in_v = tv_r;
      assign in_t = tt_r;
      assign in_s = ts_r;
    end else begin : g_next
      assign in_v = av_r[k-1];
      assign in_t = at_r[k-1];
      assign in_s = as_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mv_r[k] <= 1'b0;
        av_r[k] <= 1'b0;
      end else begin
        mv_r[k] <= in_v;
        av_r[k] <= mv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      mt_r[k] <= in_t;
      ms_r[k] <= in_s;
      at_r[k] <= mt_r[k];
      as_r[k] <= ms_r[k];
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
      ppm_pkg::acc_t        src;
      logic signed [PW-1:0] shifted;

      if (k == 0) begin : g_top
        assign src = ppm_pkg::coef(ppm_pkg::chan_t'(c), 4'(COEFF_COUNT - 1));
      end else begin : g_acc
        assign src = acc_r[k-1][c];
      end

      assign shifted = prod_r[k][c] >>> NQ;

      always_ff @(posedge clk) begin
        prod_r[k][c] <= PW'(src) * PW'($signed({1'b0, in_t}));
        acc_r[k][c]  <= AW'(shifted)
                        + ppm_pkg::coef(ppm_pkg::chan_t'(c), 4'(COEFF_COUNT - 2 - k));
      end
    end
  end

  // Scale by 255, round half up, saturate.
  logic [7:0] chan8 [3];

  for (genvar c = 0; c < 3; c++) begin : g_fin
    logic signed [FW-1:0] scaled;
    logic signed [FW-1:0] lvl;
    assign scaled = (FW'(acc_r[STEPS-1][c]) <<< 8) - FW'(acc_r[STEPS-1][c])
                    + FW'(1 << (ppm_pkg::FRAC_W - 1));
    assign lvl    = scaled >>> ppm_pkg::FRAC_W;
    always_comb begin
      if (lvl < 0) begin
        chan8[c] = 8'd0;
      end else if (lvl > FW'(255)) begin
        chan8[c] = 8'd255;
      end else begin
        chan8[c] = lvl[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= av_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!as_r[STEPS-1].mode) begin
      out_red   <= chan8[0];
      out_green <= chan8[1];
      out_blue  <= chan8[2];
    end else if (as_r[STEPS-1].blue_only) begin
      out_red   <= 8'd0;
      out_green <= 8'd0;
      out_blue  <= 8'd255;
    end else begin
      out_red   <= as_r[STEPS-1].lin;
      out_green <= as_r[STEPS-1].lin;
      out_blue  <= 8'd255;
    end
  end

endmodule

### dv/polynomial_pseudocolor_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// Polynomial pseudocolor mapper testbench
// Drives pixel words and APB register writes, predicts each RGB word from a
// fixed-point model of both color maps and compares it with the block output.
// ----------------------------------------------------------------------------
module polynomial_pseudocolor_mapper_top_tb;

  localparam int COEFF_COUNT = 10;
  localparam int VALUE_BITS  = 20;
  localparam int LATENCY     = 2*COEFF_COUNT + 18;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 700;
  localparam logic [19:0] VMAX = 20'hFFFFF;
  localparam logic MODE_VIRIDIS = 1'b0;
  localparam logic MODE_LINEAR  = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct {
    logic [19:0] cmax;
    logic        mode;
    logic [19:0] pixel;
    logic        known;
    rgb_t        rgb;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [VALUE_BITS-1:0] in_pixel_value;
  logic                  out_valid;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  logic [19:0] model_cmax;
  logic        model_mode;
  rgb_t        pending_colors[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet_stretch;

  polynomial_pseudocolor_mapper_top #(
    .COEFF_COUNT(COEFF_COUNT),
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pixel_value(in_pixel_value), .out_valid(out_valid),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint floor_div16(longint x);
    return x >>> 16;
  endfunction

  function automatic logic [7:0] horner_channel(ppm_pkg::chan_t ch, longint t);
    longint acc;
    longint coefs[ppm_pkg::TAB_LEN];
    longint level;
    for (int i = 0; i < ppm_pkg::TAB_LEN; i++) begin
      case (ch)
        ppm_pkg::CH_RED:   coefs[i] = longint'(ppm_pkg::RED_POLY[i]);
        ppm_pkg::CH_GREEN: coefs[i] = longint'(ppm_pkg::GREEN_POLY[i]);
        default:           coefs[i] = longint'(ppm_pkg::BLUE_POLY[i]);
      endcase
    end
    acc = coefs[COEFF_COUNT-1];
    for (int i = COEFF_COUNT - 2; i >= 0; i--) begin
      acc = floor_div16(acc * t) + coefs[i];
    end
    level = (acc * 255 + (longint'(1) << 23)) >>> 24;
    if (level < 0) level = 0;
    if (level > 255) level = 255;
    return level[7:0];
  endfunction

  function automatic rgb_t map_color(logic [19:0] pixel, logic [19:0] cmax_reg, logic mode);
    longint cmax;
    longint v;
    longint t;
    longint lvl;
    rgb_t c;
    cmax = (cmax_reg == 0) ? 1 : longint'(cmax_reg);
    v = longint'(pixel);
    if (mode == MODE_VIRIDIS) begin
      t = (v >= cmax) ? 65536 : (v << 16) / cmax;
      c.red   = horner_channel(ppm_pkg::CH_RED, t);
      c.green = horner_channel(ppm_pkg::CH_GREEN, t);
      c.blue  = horner_channel(ppm_pkg::CH_BLUE, t);
    end else if (v > cmax) begin
      c = '{8'd0, 8'd0, 8'd255};
    end else begin
      lvl = (2 * 255 * (cmax - v) + cmax) / (2 * cmax);
      if (lvl > 255) lvl = 255;
      c = '{lvl[7:0], lvl[7:0], 8'd255};
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(ppm_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ppm_pkg::REG_COLOR_MAX) model_cmax = value[19:0];
    else model_mode = value[0];
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic send_pixel(logic [19:0] pixel, bit may_idle);
    while (may_idle && !quiet_stretch && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_pixel_value <= pixel;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_colors.push_back(map_color(pixel, model_cmax, model_mode));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = pending_colors.pop_front();
        if (out_red != want.red) report_mismatch("red", out_red, want.red);
        if (out_green != want.green) report_mismatch("green", out_green, want.green);
        if (out_blue != want.blue) report_mismatch("blue", out_blue, want.blue);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout");
      $display("FAILED: results differ");
      $finish;
    end
  end

  row_t rows[$];
  rgb_t got_typed;

  initial begin
    logic [19:0] pix;
    quiet_stretch = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    model_cmax = VMAX;
    model_mode = MODE_VIRIDIS;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Typed results come straight from the map: zero count, saturated count,
    // blue above the scale, white at zero, and the color_max of zero case.
    rows.push_back('{VMAX, MODE_VIRIDIS, 20'd0, 1'b0, '0});
    rows.push_back('{VMAX, MODE_VIRIDIS, VMAX, 1'b0, '0});
    rows.push_back('{VMAX, MODE_VIRIDIS, 20'd524288, 1'b0, '0});
    rows.push_back('{20'd1000, MODE_VIRIDIS, 20'd999, 1'b0, '0});
    rows.push_back('{20'd1000, MODE_VIRIDIS, 20'd1000, 1'b0, '0});
    rows.push_back('{20'd1000, MODE_VIRIDIS, VMAX, 1'b0, '0});
    rows.push_back('{20'd0, MODE_VIRIDIS, 20'd0, 1'b0, '0});
    rows.push_back('{20'd0, MODE_VIRIDIS, 20'd5, 1'b0, '0});
    rows.push_back('{20'd1, MODE_VIRIDIS, 20'd1, 1'b0, '0});
    rows.push_back('{20'd1000, MODE_LINEAR, 20'd0, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{20'd1000, MODE_LINEAR, 20'd1000, 1'b1, '{8'd0, 8'd0, 8'd255}});
    rows.push_back('{20'd1000, MODE_LINEAR, 20'd1001, 1'b1, '{8'd0, 8'd0, 8'd255}});
    rows.push_back('{20'd1000, MODE_LINEAR, VMAX, 1'b1, '{8'd0, 8'd0, 8'd255}});
    rows.push_back('{20'd1000, MODE_LINEAR, 20'd500, 1'b0, '0});
    rows.push_back('{20'd0, MODE_LINEAR, 20'd0, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{20'd0, MODE_LINEAR, 20'd1, 1'b1, '{8'd0, 8'd0, 8'd255}});
    rows.push_back('{20'd2, MODE_LINEAR, 20'd1, 1'b0, '0});
    rows.push_back('{VMAX, MODE_LINEAR, 20'd0, 1'b1, '{8'd255, 8'd255, 8'd255}});
    rows.push_back('{VMAX, MODE_LINEAR, VMAX, 1'b1, '{8'd0, 8'd0, 8'd255}});
    rows.push_back('{VMAX, MODE_LINEAR, 20'h5A5A5, 1'b0, '0});

    foreach (rows[i]) begin
      if (i == 0 || rows[i].cmax != model_cmax || rows[i].mode != model_mode) begin
        drain();
        write_reg(ppm_pkg::REG_COLOR_MAX, {12'hFFF, rows[i].cmax});
        write_reg(ppm_pkg::REG_MAP_MODE, {31'h7FFFFFFF, rows[i].mode});
      end
      if (rows[i].known) begin
        got_typed = map_color(rows[i].pixel, model_cmax, model_mode);
        if (got_typed != rows[i].rgb) report_mismatch("typed row", got_typed, rows[i].rgb);
      end
      send_pixel(rows[i].pixel, 1'b0);
    end
    start <= 1'b0;

    for (int phase = 0; phase < 7; phase++) begin
      drain();
      case (phase)
        0: write_reg(ppm_pkg::REG_COLOR_MAX, VMAX);
        1: write_reg(ppm_pkg::REG_COLOR_MAX, 32'd1);
        2: write_reg(ppm_pkg::REG_COLOR_MAX, $urandom_range(1, 4095));
        default: write_reg(ppm_pkg::REG_COLOR_MAX, $urandom_range(1, 1048575));
      endcase
      write_reg(ppm_pkg::REG_MAP_MODE, phase % 2);
      quiet_stretch = (phase == 3);
      for (int n = 0; n < RANDOM_WORDS / 7; n++) begin
        case ($urandom_range(3))
          0: pix = 20'($urandom);
          1: pix = 20'($urandom_range(0, model_cmax));
          2: pix = 20'(model_cmax + $urandom_range(0, 2) - 1);
          default: pix = 20'($urandom_range(0, 16));
        endcase
        send_pixel(pix, 1'b1);
        if (n == 50) begin
          start <= 1'b0;
          while (pending_colors.size() != 0) @(negedge clk);
        end
      end
      start <= 1'b0;
    end

    drain();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
